// ===== hdl/sfcv_pkg.sv =====
// ----------------------------------------------------------------------------
// Sensor frame checksum validator package
// Shared widths, status codes, register indexes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcv_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TYPE_W     = 4;
  localparam int unsigned ID_W       = 48;
  localparam int unsigned POS_W      = 9;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned ID_LAST    = 7;
  localparam int unsigned SUM_OFFSET = 8;

  localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET = 8'd119;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_WRONG_TYPE   = 2'd1,
    ST_BAD_LENGTH   = 2'd2,
    ST_SUM_MISMATCH = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MESSAGE_TYPE = 8'd0,
    CFG_MAX_LENGTH   = 8'd1
  } cfg_index_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   sensor_id;
    logic [BYTE_W-1:0] payload_length;
    logic [BYTE_W-1:0] computed_sum;
  } result_t;

  typedef struct packed {
    logic [TYPE_W-1:0] message_type;
    logic [BYTE_W-1:0] max_payload_length;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/sfcv_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the expected message type and the largest accepted payload length.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcv_cfg_regs
  import sfcv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data,
  output cfg_t                      cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.message_type       <= '0;
      cfg.max_payload_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MESSAGE_TYPE: cfg.message_type       <= cfg_data[BYTE_W-1 -: TYPE_W] & 4'h0
                                                    | cfg_data[TYPE_W-1:0];
        CFG_MAX_LENGTH:   cfg.max_payload_length <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sfcv_frame_engine.sv =====
// ----------------------------------------------------------------------------
// Frame engine
// Tracks the position within a frame, checks type and length, accumulates
// the wrapping sum and captures the sensor ID, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcv_frame_engine
  import sfcv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic              frame_start,
  input  wire cfg_t              cfg,
  output logic                   emit,
  output result_t                res
);

  logic              frame_active, frame_active_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [BYTE_W-1:0] length_held, length_held_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [ID_W-1:0]   id_held, id_held_next;
  logic [BYTE_W-1:0] sum_plus;
  logic [POS_W-1:0]  sum_position;

  assign sum_plus     = running_sum + data_byte;
  assign sum_position = {1'b0, length_held} + POS_W'(SUM_OFFSET);

  always_comb begin
    frame_active_next  = frame_active;
    byte_position_next = byte_position;
    length_held_next   = length_held;
    running_sum_next   = running_sum;
    id_held_next       = id_held;
    emit               = 1'b0;
    res                = '0;

    if (frame_start) begin
      if (data_byte[BYTE_W-1 -: TYPE_W] != cfg.message_type) begin
        emit              = 1'b1;
        res.status        = ST_WRONG_TYPE;
        frame_active_next = 1'b0;
      end else begin
        frame_active_next  = 1'b1;
        byte_position_next = POS_W'(1);
        length_held_next   = '0;
        running_sum_next   = data_byte;
        id_held_next       = '0;
      end
    end else if (frame_active) begin
      if (byte_position == POS_W'(1)) begin
        if (data_byte == '0 || data_byte > cfg.max_payload_length) begin
          emit               = 1'b1;
          res.status         = ST_BAD_LENGTH;
          res.payload_length = data_byte;
          frame_active_next  = 1'b0;
        end else begin
          length_held_next   = data_byte;
          running_sum_next   = sum_plus;
          byte_position_next = POS_W'(2);
        end
      end else if (byte_position == sum_position) begin
        // Checksum byte: the frame closes with its verdict.
        emit               = 1'b1;
        res.status         = (data_byte == running_sum) ? ST_ACCEPTED : ST_SUM_MISMATCH;
        res.sensor_id      = id_held;
        res.payload_length = length_held;
        res.computed_sum   = running_sum;
        frame_active_next  = 1'b0;
      end else begin
        if (byte_position <= POS_W'(ID_LAST)) begin
          id_held_next = {id_held[ID_W-BYTE_W-1:0], data_byte};
        end
        running_sum_next   = sum_plus;
        byte_position_next = byte_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active  <= 1'b0;
      byte_position <= '0;
      length_held   <= '0;
      running_sum   <= '0;
      id_held       <= '0;
    end else if (step) begin
      frame_active  <= frame_active_next;
      byte_position <= byte_position_next;
      length_held   <= length_held_next;
      running_sum   <= running_sum_next;
      id_held       <= id_held_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sfcv_out_reg.sv =====
// ----------------------------------------------------------------------------
// Result register
// Holds one finished result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcv_out_reg
  import sfcv_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t res_in,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      res_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sensor_frame_checksum_validator_unit.sv =====
// ----------------------------------------------------------------------------
// Sensor frame checksum validator
// Checks radio frame bytes for message type, length and additive checksum.
// ----------------------------------------------------------------------------
// The block takes one byte item per clock cycle and keeps that rate as long
// as the result side takes its results. Each byte passes an input register,
// then one step of the frame engine whose status result, if any, lands in
// the result register. At most one result is given per frame: at the first
// rejection or at the checksum byte. The input register and the result
// register are the only stages; a stalled result holds the next byte in the
// input register until it is taken.
`default_nettype none

module sensor_frame_checksum_validator_unit
  import sfcv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [BYTE_W-1:0]    data_byte,
  input  wire logic                 frame_start,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                status,
  output logic [ID_W-1:0]           sensor_id,
  output logic [BYTE_W-1:0]         payload_length,
  output logic [BYTE_W-1:0]         computed_sum,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [BYTE_W-1:0]    cfg_data
);

  cfg_t              cfg;
  logic              in_full;
  logic [BYTE_W-1:0] byte_q;
  logic              start_q;
  logic              advance;
  logic              emit;
  result_t           res;
  result_t           res_out;

  sfcv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q  <= data_byte;
      start_q <= frame_start;
    end
  end

  sfcv_frame_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .data_byte   (byte_q),
    .frame_start (start_q),
    .cfg         (cfg),
    .emit        (emit),
    .res         (res)
  );

  sfcv_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .res_in    (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign status         = res_out.status;
  assign sensor_id      = res_out.sensor_id;
  assign payload_length = res_out.payload_length;
  assign computed_sum   = res_out.computed_sum;

endmodule

`default_nettype wire

// ===== hdl/sfcv_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the validator's ports for result timing and result contents.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcv_checker
  import sfcv_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [1:0]        status,
  input wire logic [ID_W-1:0]   sensor_id,
  input wire logic [BYTE_W-1:0] payload_length,
  input wire logic [BYTE_W-1:0] computed_sum
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(sensor_id)
      && $stable(payload_length) && $stable(computed_sum))
    else $error("result changed while stalled");

  // A fresh result must trace back to an accepted item through the input register and the result register.
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching item");

  // A type rejection carries no frame contents.
  a_type_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_WRONG_TYPE |->
      sensor_id == '0 && payload_length == '0 && computed_sum == '0)
    else $error("type rejection with nonzero fields");

  // A length rejection carries no ID and no sum.
  a_length_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_BAD_LENGTH |-> sensor_id == '0 && computed_sum == '0)
    else $error("length rejection with nonzero fields");

endmodule

bind sensor_frame_checksum_validator_unit sfcv_checker u_sfcv_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .status         (status),
  .sensor_id      (sensor_id),
  .payload_length (payload_length),
  .computed_sum   (computed_sum)
);

`default_nettype wire

// ===== tb/sv/tb_sensor_frame_checksum_validator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor frame checksum validator testbench
// Drives byte items as frames of every kind (good, bad type, bad length, bad
// checksum, cut short, loose bytes) under several register settings, with
// bursty input and a stalling result side. A frame tracker in the bench works
// out each status result and compares it field by field with the block.
// ----------------------------------------------------------------------------

module tb_sensor_frame_checksum_validator_unit;
  import sfcv_pkg::*;

  typedef enum {FR_GOOD, FR_BAD_SUM, FR_BAD_TYPE, FR_BAD_LEN, FR_CUT, FR_NOISE} frame_kind_t;

  // Tracks the frame as the block should see it and holds the status results
  // still owed by the block.
  class frame_tracker;
    logic [TYPE_W-1:0] msg_type;
    logic [BYTE_W-1:0] max_len;
    bit                in_frame;
    logic [POS_W-1:0]  pos;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] sum;
    logic [ID_W-1:0]   id;
    result_t           pending_status[$];
    int                errors;
    int                live_items;
    int                seen[4];

    function new();
      msg_type   = '0;
      max_len    = MAX_LENGTH_RESET;
      in_frame   = 1'b0;
      pos        = '0;
      len        = '0;
      sum        = '0;
      id         = '0;
      errors     = 0;
      live_items = 0;
      foreach (seen[i]) seen[i] = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [BYTE_W-1:0] d);
      if (idx == CFG_MESSAGE_TYPE) begin
        msg_type = d[TYPE_W-1:0];
      end else if (idx == CFG_MAX_LENGTH) begin
        max_len = d;
      end
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b, logic s);
      result_t r;
      bit      give;
      give = 1'b0;
      r = '0;
      if (s || in_frame) live_items++;
      if (s) begin
        if (b[7:4] != msg_type) begin
          r.status = ST_WRONG_TYPE;
          give = 1'b1;
          in_frame = 1'b0;
        end else begin
          in_frame = 1'b1;
          pos = POS_W'(1);
          len = '0;
          sum = b;
          id = '0;
        end
      end else if (in_frame) begin
        if (pos == 1) begin
          if (b == 0 || b > max_len) begin
            r.status = ST_BAD_LENGTH;
            r.payload_length = b;
            give = 1'b1;
            in_frame = 1'b0;
          end else begin
            len = b;
            sum = sum + b;
            pos = POS_W'(2);
          end
        end else if (pos == {1'b0, len} + POS_W'(SUM_OFFSET)) begin
          r.status = (b == sum) ? ST_ACCEPTED : ST_SUM_MISMATCH;
          r.sensor_id = id;
          r.payload_length = len;
          r.computed_sum = sum;
          give = 1'b1;
          in_frame = 1'b0;
        end else begin
          if (pos <= POS_W'(ID_LAST)) id = {id[ID_W-9:0], b};
          sum = sum + b;
          pos = pos + 1'b1;
        end
      end
      if (give) pending_status.push_back(r);
    endfunction

    function void check_status(result_t got);
      result_t want;
      if (got.status !== 2'bxx) seen[got.status]++;
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: result with nothing expected, status %0d", $time, got.status);
        return;
      end
      want = pending_status.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.sensor_id !== want.sensor_id) begin
        errors++;
        $display("%0t: sensor_id expected %h actual %h", $time, want.sensor_id,
                 got.sensor_id);
      end
      if (got.payload_length !== want.payload_length) begin
        errors++;
        $display("%0t: payload_length expected %h actual %h", $time,
                 want.payload_length, got.payload_length);
      end
      if (got.computed_sum !== want.computed_sum) begin
        errors++;
        $display("%0t: computed_sum expected %h actual %h", $time, want.computed_sum,
                 got.computed_sum);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [BYTE_W-1:0]    data_byte = '0;
  logic                 frame_start = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           status;
  logic [ID_W-1:0]      sensor_id;
  logic [BYTE_W-1:0]    payload_length;
  logic [BYTE_W-1:0]    computed_sum;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [BYTE_W-1:0]    cfg_data = '0;

  frame_tracker      tracker = new();
  result_t           observed;
  logic [TYPE_W-1:0] cur_type = '0;
  logic [BYTE_W-1:0] cur_max = MAX_LENGTH_RESET;
  int                burst_left = 0;
  int                frames_sent = 0;
  int                settings_used = 0;
  int                hold_requests = 0;
  int                holds_done = 0;

  sensor_frame_checksum_validator_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .frame_start    (frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .sensor_id      (sensor_id),
    .payload_length (payload_length),
    .computed_sum   (computed_sum),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      observed.status = status_t'(status);
      observed.sensor_id = sensor_id;
      observed.payload_length = payload_length;
      observed.computed_sum = computed_sum;
      tracker.check_status(observed);
    end
  end

  // Result side: random stall patterns in segments, plus a long hold-off on
  // request so that the block backs up into its input.
  initial begin
    int seg;
    int mode;
    @(posedge clk);
    forever begin
      mode = $urandom_range(0, 2);
      seg = $urandom_range(20, 120);
      repeat (seg) begin
        if (holds_done < hold_requests) begin
          holds_done++;
          out_ready <= 1'b0;
          repeat (300) @(posedge clk);
        end else begin
          case (mode)
            0: begin
              out_ready <= 1'b1;
            end
            1: begin
              out_ready <= 1'($urandom_range(0, 1));
            end
            default: begin
              out_ready <= ($urandom_range(0, 7) != 0);
            end
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic s);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4))
        @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    frame_start <= s;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b, s);
    burst_left--;
  endtask

  task automatic send_seq(input logic [BYTE_W-1:0] q[$], input logic starts);
    foreach (q[i]) send_byte(q[i], starts && (i == 0));
  endtask

  function automatic logic [BYTE_W-1:0] byte_sum(input logic [BYTE_W-1:0] q[$]);
    logic [BYTE_W-1:0] acc;
    acc = '0;
    foreach (q[i]) acc = acc + q[i];
    return acc;
  endfunction

  function automatic int pick_len();
    int lim;
    lim = (cur_max == 0) ? 8 : int'(cur_max);
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, (lim < 8) ? lim : 8);
    return $urandom_range(1, (lim < 40) ? lim : 40);
  endfunction

  function automatic logic [BYTE_W-1:0] bad_len();
    if (cur_max == 8'hFF || $urandom_range(0, 3) == 0) return '0;
    return BYTE_W'($urandom_range(int'(cur_max) + 1, 255));
  endfunction

  task automatic send_frame(input frame_kind_t kind, input int force_len);
    logic [BYTE_W-1:0] fb[$];
    logic [BYTE_W-1:0] hdr;
    int                n;
    int                keep;
    hdr = {cur_type, 4'($urandom_range(0, 15))};
    case (kind)
      FR_NOISE: begin
        repeat ($urandom_range(1, 4)) fb.push_back(BYTE_W'($urandom));
        send_seq(fb, 1'b0);
        return;
      end
      FR_BAD_TYPE: begin
        hdr[7:4] = cur_type ^ 4'($urandom_range(1, 15));
        fb.push_back(hdr);
      end
      FR_BAD_LEN: begin
        fb.push_back(hdr);
        fb.push_back(bad_len());
      end
      default: begin
        n = (force_len > 0) ? force_len : pick_len();
        fb.push_back(hdr);
        fb.push_back(BYTE_W'(n));
        repeat (6 + n) fb.push_back(BYTE_W'($urandom));
        fb.push_back(byte_sum(fb) ^
                     ((kind == FR_BAD_SUM) ? BYTE_W'($urandom_range(1, 255)) : 8'h00));
        if (kind == FR_CUT) begin
          keep = $urandom_range(1, fb.size() - 1);
          while (fb.size() > keep) void'(fb.pop_back());
        end
      end
    endcase
    // Bytes after a closed frame must be ignored by the block.
    if (kind != FR_CUT && $urandom_range(0, 6) == 0)
      repeat ($urandom_range(1, 3)) fb.push_back(BYTE_W'($urandom));
    send_seq(fb, 1'b1);
    frames_sent++;
  endtask

  task automatic send_random_frame();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) send_frame(FR_GOOD, 0);
    else if (r < 58) send_frame(FR_BAD_SUM, 0);
    else if (r < 70) send_frame(FR_BAD_TYPE, 0);
    else if (r < 81) send_frame(FR_BAD_LEN, 0);
    else if (r < 92) send_frame(FR_CUT, 0);
    else send_frame(FR_NOISE, 0);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic program_regs(input logic [TYPE_W-1:0] t, input logic [BYTE_W-1:0] m);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MESSAGE_TYPE;
    cfg_data <= BYTE_W'(t);
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(CFG_MESSAGE_TYPE, BYTE_W'(t));
    cfg_index <= CFG_MAX_LENGTH;
    cfg_data <= m;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_reg(CFG_MAX_LENGTH, m);
    cfg_valid <= 1'b0;
    cur_type = t;
    cur_max = m;
    settings_used++;
    @(posedge clk);
  endtask

  task automatic run_phase(input logic [TYPE_W-1:0] t, input logic [BYTE_W-1:0] m,
                           input int big_len, input bit long_hold);
    int start_items;
    program_regs(t, m);
    if (long_hold) hold_requests++;
    if (big_len > 0) send_frame(FR_GOOD, big_len);
    start_items = tracker.live_items;
    while (tracker.live_items - start_items < 20) send_random_frame();
    wait_idle();
  endtask

  initial begin
    logic [BYTE_W-1:0] seq[$];
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part under reset settings: type 0, length limit 119.
    seq = {8'h0F, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    seq.push_back(byte_sum(seq));
    send_seq(seq, 1'b1);
    // Zero-filled frame of length 1 whose zero checksum byte does not match the sum of 1.
    seq = {8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    send_seq(seq, 1'b1);
    seq = {8'hF0};
    send_seq(seq, 1'b1);
    seq = {8'h05, 8'h00};
    send_seq(seq, 1'b1);
    seq = {8'h0A, 8'd120};
    send_seq(seq, 1'b1);
    // Loose byte with no frame open.
    seq = {8'hA5};
    send_seq(seq, 1'b0);
    frames_sent += 5;
    wait_idle();

    run_phase(4'hF, 8'hFF, 255, 1'b1);
    run_phase(4'($urandom_range(0, 15)), 8'd1, 0, 1'b0);
    run_phase(4'($urandom_range(0, 15)), 8'd0, 0, 1'b0);
    run_phase(4'h0, MAX_LENGTH_RESET, int'(MAX_LENGTH_RESET), 1'b1);
    run_phase(4'($urandom_range(0, 15)), 8'($urandom_range(2, 254)), 0, 1'b0);
    run_phase(4'hA, 8'd40, 40, 1'b0);

    repeat (10) @(posedge clk);
    $display("Sent %0d frames (%0d live byte items) across %0d register settings.",
             frames_sent, tracker.live_items, settings_used);
    $display("Results: %0d accepted, %0d wrong type, %0d bad length, %0d checksum mismatch.",
             tracker.seen[0], tracker.seen[1], tracker.seen[2], tracker.seen[3]);
    if (tracker.errors == 0 && tracker.pending_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
